### rtl/tepb_pkg.sv
package tepb_pkg;

	// Default for the largest texture side; coordinates are wide enough to hold it.
	localparam int MAX_TEXTURE_SIZE_DEF = 4096;

	// Q0.16 fractions and the Q4.12 edge reach register.
	localparam int Q16_BITS    = 16;
	localparam int EDW         = 16;
	localparam int ED_FRAC     = 12;
	localparam int RATIO_SHIFT = Q16_BITS - ED_FRAC;

	// Quotient bits resolved in each divider stage.
	localparam int DIV_BITS_PER_STAGE = 2;
	localparam int DIV_STAGES         = Q16_BITS / DIV_BITS_PER_STAGE;

	// From the start cycle to the cycle in which done is high.
	localparam int PIPE_LATENCY = 2 * DIV_STAGES + 7;

	// Colour channels.
	localparam int NCH      = 4;
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;
	localparam int CH_ALPHA = 3;

	typedef logic [7:0]          chan_t;
	typedef chan_t [NCH-1:0]     pixel_t;

	// Configuration space.
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	typedef enum logic [2:0] {
		REG_EDGE_DISTANCE = 3'd0,
		REG_EDGE_RED      = 3'd1,
		REG_EDGE_GREEN    = 3'd2,
		REG_EDGE_BLUE     = 3'd3,
		REG_EDGE_ALPHA    = 3'd4
	} cfg_reg_t;

	localparam logic [EDW-1:0] EDGE_DISTANCE_RST = '0;
	localparam chan_t          EDGE_RED_RST      = 8'd255;
	localparam chan_t          EDGE_GREEN_RST    = 8'd255;
	localparam chan_t          EDGE_BLUE_RST     = 8'd255;
	localparam chan_t          EDGE_ALPHA_RST    = 8'd96;

endpackage

### rtl/tile_edge_proximity_blend.sv
// Channel   Handshake                 Payload
// pixel in  start / busy              pos_x, pos_y, tile_left/right/top/bottom, in_red..in_alpha
// pixel out done (one-cycle strobe)   out_red, out_green, out_blue, out_alpha
// config    psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One pixel is taken in every cycle; busy never rises.
// Each result passes through the two restoring dividers, of 8 stages each, on its way to the ports.
// Reset clears the stage valid bits and loads the register reset values.
// The receiver cannot stall, so the pipeline advances in every cycle.
module tile_edge_proximity_blend
	import tepb_pkg::*;
#(
	parameter int MAX_TEXTURE_SIZE = MAX_TEXTURE_SIZE_DEF,
	localparam int CW = $clog2(MAX_TEXTURE_SIZE + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CW-1:0]     pos_x,
	input  logic [CW-1:0]     pos_y,
	input  logic [CW-1:0]     tile_left,
	input  logic [CW-1:0]     tile_right,
	input  logic [CW-1:0]     tile_top,
	input  logic [CW-1:0]     tile_bottom,
	input  logic [7:0]        in_red,
	input  logic [7:0]        in_green,
	input  logic [7:0]        in_blue,
	input  logic [7:0]        in_alpha,
	output logic              done,
	output logic [7:0]        out_red,
	output logic [7:0]        out_green,
	output logic [7:0]        out_blue,
	output logic [7:0]        out_alpha,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output logic [CFG_DW-1:0] prdata,
	output logic              pready
);

	localparam int PM_W = 8 + Q16_BITS;
	localparam int CM_W = 8 + Q16_BITS + 1;

	// Configuration registers.
	logic [EDW-1:0] ed_q;
	pixel_t         ec_q;
	logic           cfg_wr;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ed_q           <= EDGE_DISTANCE_RST;
			ec_q[CH_RED]   <= EDGE_RED_RST;
			ec_q[CH_GREEN] <= EDGE_GREEN_RST;
			ec_q[CH_BLUE]  <= EDGE_BLUE_RST;
			ec_q[CH_ALPHA] <= EDGE_ALPHA_RST;
		end else if (cfg_wr) begin
			case (cfg_reg_t'(paddr[4:2]))
				REG_EDGE_DISTANCE: ed_q           <= pwdata[EDW-1:0];
				REG_EDGE_RED:      ec_q[CH_RED]   <= pwdata[7:0];
				REG_EDGE_GREEN:    ec_q[CH_GREEN] <= pwdata[7:0];
				REG_EDGE_BLUE:     ec_q[CH_BLUE]  <= pwdata[7:0];
				REG_EDGE_ALPHA:    ec_q[CH_ALPHA] <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_reg_t'(paddr[4:2]))
			REG_EDGE_DISTANCE: prdata = CFG_DW'(ed_q);
			REG_EDGE_RED:      prdata = CFG_DW'(ec_q[CH_RED]);
			REG_EDGE_GREEN:    prdata = CFG_DW'(ec_q[CH_GREEN]);
			REG_EDGE_BLUE:     prdata = CFG_DW'(ec_q[CH_BLUE]);
			REG_EDGE_ALPHA:    prdata = CFG_DW'(ec_q[CH_ALPHA]);
			default:           prdata = '0;
		endcase
	end

	function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	// Restoring division steps on a remainder that stays below the divisor.
	function automatic logic [CW+Q16_BITS-1:0] hdv_step(input logic [CW-1:0] rem,
			input logic [Q16_BITS-1:0] quo, input logic [CW-1:0] dvs);
		logic [CW:0]         t;
		logic [CW-1:0]       r;
		logic [Q16_BITS-1:0] q;
		r = rem;
		q = quo;
		for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
			t = {r, 1'b0};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				q = {q[Q16_BITS-2:0], 1'b1};
			end else begin
				q = {q[Q16_BITS-2:0], 1'b0};
			end
			r = t[CW-1:0];
		end
		return {r, q};
	endfunction

	// Same, with the low numerator bits shifted in from nlo.
	function automatic logic [EDW+2*Q16_BITS-1:0] rdv_step(input logic [EDW-1:0] rem,
			input logic [Q16_BITS-1:0] quo, input logic [Q16_BITS-1:0] nlo,
			input logic [EDW-1:0] dvs);
		logic [EDW:0]        t;
		logic [EDW-1:0]      r;
		logic [Q16_BITS-1:0] q;
		logic [Q16_BITS-1:0] n;
		r = rem;
		q = quo;
		n = nlo;
		for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
			t = {r, n[Q16_BITS-1]};
			n = {n[Q16_BITS-2:0], 1'b0};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				q = {q[Q16_BITS-2:0], 1'b1};
			end else begin
				q = {q[Q16_BITS-2:0], 1'b0};
			end
			r = t[EDW-1:0];
		end
		return {r, q, n};
	endfunction

	// Stage 1: distances to both bounds and tile sizes.
	logic          v_s1, ok_s1;
	logic [CW-1:0] ax_s1, bx_s1, sx_s1, ay_s1, by_s1, sy_s1;
	pixel_t        pix_s1;
	logic          in_xfer;

	assign in_xfer = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= in_xfer;
	end

	always_ff @(posedge clk) begin
		ax_s1            <= abs_diff(tile_left, pos_x);
		bx_s1            <= abs_diff(tile_right, pos_x);
		sx_s1            <= tile_right - tile_left;
		ay_s1            <= abs_diff(tile_top, pos_y);
		by_s1            <= abs_diff(tile_bottom, pos_y);
		sy_s1            <= tile_bottom - tile_top;
		ok_s1            <= (tile_right > tile_left) && (tile_bottom > tile_top) && (ed_q != '0);
		pix_s1[CH_RED]   <= in_red;
		pix_s1[CH_GREEN] <= in_green;
		pix_s1[CH_BLUE]  <= in_blue;
		pix_s1[CH_ALPHA] <= in_alpha;
	end

	// Edge dividers; index 0 is stage 2, where the nearer bound is picked. A bound
	// distance at or beyond the tile size saturates the Q0.16 fraction.
	logic                hdv_v_s   [0:DIV_STAGES];
	logic                hdv_ok_s  [0:DIV_STAGES];
	pixel_t              hdv_pix_s [0:DIV_STAGES];
	logic [CW-1:0]       xrem_s    [0:DIV_STAGES];
	logic [Q16_BITS-1:0] xquo_s    [0:DIV_STAGES];
	logic [CW-1:0]       xsize_s   [0:DIV_STAGES];
	logic                xsat_s    [0:DIV_STAGES];
	logic [CW-1:0]       yrem_s    [0:DIV_STAGES];
	logic [Q16_BITS-1:0] yquo_s    [0:DIV_STAGES];
	logic [CW-1:0]       ysize_s   [0:DIV_STAGES];
	logic                ysat_s    [0:DIV_STAGES];
	logic [CW-1:0]       mx, my;

	assign mx = (ax_s1 < bx_s1) ? ax_s1 : bx_s1;
	assign my = (ay_s1 < by_s1) ? ay_s1 : by_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) hdv_v_s[0] <= 1'b0;
		else         hdv_v_s[0] <= v_s1;
	end

	always_ff @(posedge clk) begin
		hdv_ok_s[0]  <= ok_s1;
		hdv_pix_s[0] <= pix_s1;
		xsat_s[0]    <= mx >= sx_s1;
		xrem_s[0]    <= (mx >= sx_s1) ? '0 : mx;
		xquo_s[0]    <= '0;
		xsize_s[0]   <= sx_s1;
		ysat_s[0]    <= my >= sy_s1;
		yrem_s[0]    <= (my >= sy_s1) ? '0 : my;
		yquo_s[0]    <= '0;
		ysize_s[0]   <= sy_s1;
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_hdv
		logic [CW+Q16_BITS-1:0] xn, yn;

		assign xn = hdv_step(xrem_s[k-1], xquo_s[k-1], xsize_s[k-1]);
		assign yn = hdv_step(yrem_s[k-1], yquo_s[k-1], ysize_s[k-1]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) hdv_v_s[k] <= 1'b0;
			else         hdv_v_s[k] <= hdv_v_s[k-1];
		end

		always_ff @(posedge clk) begin
			hdv_ok_s[k]  <= hdv_ok_s[k-1];
			hdv_pix_s[k] <= hdv_pix_s[k-1];
			xrem_s[k]    <= xn[CW+Q16_BITS-1:Q16_BITS];
			xquo_s[k]    <= xn[Q16_BITS-1:0];
			xsize_s[k]   <= xsize_s[k-1];
			xsat_s[k]    <= xsat_s[k-1];
			yrem_s[k]    <= yn[CW+Q16_BITS-1:Q16_BITS];
			yquo_s[k]    <= yn[Q16_BITS-1:0];
			ysize_s[k]   <= ysize_s[k-1];
			ysat_s[k]    <= ysat_s[k-1];
		end
	end

	// Stage 3: smaller of the two fractions.
	logic                v_s3, ok_s3;
	logic [Q16_BITS-1:0] d_s3;
	pixel_t              pix_s3;
	logic [Q16_BITS-1:0] dx, dy;

	assign dx = xsat_s[DIV_STAGES] ? '1 : xquo_s[DIV_STAGES];
	assign dy = ysat_s[DIV_STAGES] ? '1 : yquo_s[DIV_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else         v_s3 <= hdv_v_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		d_s3   <= (dx < dy) ? dx : dy;
		ok_s3  <= hdv_ok_s[DIV_STAGES];
		pix_s3 <= hdv_pix_s[DIV_STAGES];
	end

	// Ratio divider; index 0 is stage 4. The ratio reaches 1.0 exactly when
	// d >= 16 * edge_distance, and below that its quotient fits in 16 bits.
	logic                rdv_v_s    [0:DIV_STAGES];
	logic                rdv_pass_s [0:DIV_STAGES];
	pixel_t              rdv_pix_s  [0:DIV_STAGES];
	logic [EDW-1:0]      rrem_s     [0:DIV_STAGES];
	logic [Q16_BITS-1:0] rquo_s     [0:DIV_STAGES];
	logic [Q16_BITS-1:0] rnlo_s     [0:DIV_STAGES];
	logic                ratio_big;

	assign ratio_big = {{RATIO_SHIFT{1'b0}}, d_s3} >= {ed_q, {RATIO_SHIFT{1'b0}}};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rdv_v_s[0] <= 1'b0;
		else         rdv_v_s[0] <= v_s3;
	end

	always_ff @(posedge clk) begin
		rdv_pass_s[0] <= !ok_s3 || ratio_big;
		rdv_pix_s[0]  <= pix_s3;
		rrem_s[0]     <= ratio_big ? '0 : EDW'(d_s3 >> RATIO_SHIFT);
		rquo_s[0]     <= '0;
		rnlo_s[0]     <= d_s3 << ED_FRAC;
	end

	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_rdv
		logic [EDW+2*Q16_BITS-1:0] rn;

		assign rn = rdv_step(rrem_s[k-1], rquo_s[k-1], rnlo_s[k-1], ed_q);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) rdv_v_s[k] <= 1'b0;
			else         rdv_v_s[k] <= rdv_v_s[k-1];
		end

		always_ff @(posedge clk) begin
			rdv_pass_s[k] <= rdv_pass_s[k-1];
			rdv_pix_s[k]  <= rdv_pix_s[k-1];
			rrem_s[k]     <= rn[EDW+2*Q16_BITS-1:2*Q16_BITS];
			rquo_s[k]     <= rn[2*Q16_BITS-1:Q16_BITS];
			rnlo_s[k]     <= rn[Q16_BITS-1:0];
		end
	end

	// Stage 5: strength s = 1.0 - ratio; the source weight 1.0 - s is the ratio itself.
	logic                v_s5, pass_s5;
	logic [Q16_BITS-1:0] ratio_s5;
	logic [Q16_BITS:0]   s_s5;
	pixel_t              pix_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else         v_s5 <= rdv_v_s[DIV_STAGES];
	end

	always_ff @(posedge clk) begin
		pass_s5  <= rdv_pass_s[DIV_STAGES];
		ratio_s5 <= rquo_s[DIV_STAGES];
		s_s5     <= {1'b1, {Q16_BITS{1'b0}}} - {1'b0, rquo_s[DIV_STAGES]};
		pix_s5   <= rdv_pix_s[DIV_STAGES];
	end

	// Stage 6: per-channel products.
	logic            v_s6, pass_s6;
	logic [PM_W-1:0] pm_s6 [0:NCH-1];
	logic [CM_W-1:0] cm_s6 [0:NCH-1];
	pixel_t          pix_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else         v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		pass_s6 <= pass_s5;
		pix_s6  <= pix_s5;
		for (int c = 0; c < NCH; c++) begin
			pm_s6[c] <= PM_W'(pix_s5[c]) * PM_W'(ratio_s5);
			cm_s6[c] <= CM_W'(ec_q[c]) * CM_W'(s_s5);
		end
	end

	// Stage 7: sum, truncate and register the result.
	logic   done_s7;
	pixel_t out_s7;
	pixel_t blend;

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			blend[c] = 8'((CM_W'(pm_s6[c]) + cm_s6[c]) >> Q16_BITS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_s7 <= 1'b0;
		else         done_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		out_s7 <= pass_s6 ? pix_s6 : blend;
	end

	assign done      = done_s7;
	assign out_red   = out_s7[CH_RED];
	assign out_green = out_s7[CH_GREEN];
	assign out_blue  = out_s7[CH_BLUE];
	assign out_alpha = out_s7[CH_ALPHA];

endmodule

### rtl/tepb_checker.sv
module tepb_props
	import tepb_pkg::*;
#(
	parameter int MAX_TEXTURE_SIZE = MAX_TEXTURE_SIZE_DEF,
	localparam int CW = $clog2(MAX_TEXTURE_SIZE + 1)
) (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [CW-1:0]     tile_left,
	input logic [CW-1:0]     tile_right,
	input logic [7:0]        in_red,
	input logic [7:0]        in_green,
	input logic [7:0]        in_blue,
	input logic [7:0]        in_alpha,
	input logic              done,
	input logic [7:0]        out_red,
	input logic [7:0]        out_green,
	input logic [7:0]        out_blue,
	input logic [7:0]        out_alpha,
	input logic              psel,
	input logic              penable,
	input logic              pwrite,
	input logic [CFG_AW-1:0] paddr,
	input logic [CFG_DW-1:0] pwdata,
	input logic [CFG_DW-1:0] prdata,
	input logic              pready
);

	localparam int LW = $clog2(PIPE_LATENCY + 1);

	// Cycles since reset, so that looks back never reach into reset.
	logic [LW-1:0] warm_q;
	logic          warm;
	logic          in_xfer;
	logic          cfg_wr;

	assign warm    = warm_q == LW'(PIPE_LATENCY);
	assign in_xfer = start && !busy;
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)   warm_q <= '0;
		else if (!warm) warm_q <= warm_q + 1'b1;
	end

	// Every transfer in gives exactly one result, and no result comes without one.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> done == $past(in_xfer, PIPE_LATENCY))
		else $error("result strobe does not match an input transfer");

	// A tile that is empty along x leaves the pixel unchanged.
	a_empty_tile_passes: assert property (@(posedge clk) disable iff (!arst_n)
		warm && $past(in_xfer && (tile_right <= tile_left), PIPE_LATENCY) |->
		out_red == $past(in_red, PIPE_LATENCY) && out_green == $past(in_green, PIPE_LATENCY) &&
		out_blue == $past(in_blue, PIPE_LATENCY) && out_alpha == $past(in_alpha, PIPE_LATENCY))
		else $error("pixel in an empty tile was altered");

	// The edge reach register reads back what was written to it.
	a_reach_readback: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr && paddr[4:2] == REG_EDGE_DISTANCE ##1 paddr == $past(paddr) |->
		prdata == {{(CFG_DW-EDW){1'b0}}, $past(pwdata[EDW-1:0])})
		else $error("edge distance readback mismatch");

endmodule

bind tile_edge_proximity_blend tepb_props #(.MAX_TEXTURE_SIZE(MAX_TEXTURE_SIZE)) u_tepb_props (.*);

### sim/tepb_checker.sv
module tepb_checker
	import tepb_pkg::*;
#(
	parameter int CW = $clog2(MAX_TEXTURE_SIZE_DEF + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic [CW-1:0]     pos_x,
	input  logic [CW-1:0]     pos_y,
	input  logic [CW-1:0]     tile_left,
	input  logic [CW-1:0]     tile_right,
	input  logic [CW-1:0]     tile_top,
	input  logic [CW-1:0]     tile_bottom,
	input  logic [7:0]        in_red,
	input  logic [7:0]        in_green,
	input  logic [7:0]        in_blue,
	input  logic [7:0]        in_alpha,
	input  logic              done,
	input  logic [7:0]        out_red,
	input  logic [7:0]        out_green,
	input  logic [7:0]        out_blue,
	input  logic [7:0]        out_alpha,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [CFG_AW-1:0] paddr,
	input  logic [CFG_DW-1:0] pwdata,
	output int                n_pending,
	output int                n_errors
);

	timeunit 1ns;
	timeprecision 1ps;

	localparam longint unsigned ONE_Q16 = 64'd1 << Q16_BITS;
	localparam int MAX_REPORTS = 10;

	// Channels are packed with red at index 0 and alpha at index 3.
	localparam pixel_t EDGE_COL_RST = {EDGE_ALPHA_RST, EDGE_BLUE_RST, EDGE_GREEN_RST,
		EDGE_RED_RST};

	logic [EDW-1:0] edge_dist = EDGE_DISTANCE_RST;
	pixel_t         edge_col  = EDGE_COL_RST;
	pixel_t         blended_q[$];
	int             err_cnt   = 0;
	int             result_cnt = 0;

	initial begin
		n_pending = 0;
		n_errors  = 0;
	end

	// Distance to the nearer bound as a Q0.16 fraction of the span, saturated.
	function automatic logic [Q16_BITS-1:0] near_edge_frac(logic [CW-1:0] pos,
			logic [CW-1:0] lo, logic [CW-1:0] hi);
		longint unsigned to_lo, to_hi, nearest, q;
		to_lo   = (lo > pos) ? lo - pos : pos - lo;
		to_hi   = (hi > pos) ? hi - pos : pos - hi;
		nearest = (to_lo < to_hi) ? to_lo : to_hi;
		q       = (nearest << Q16_BITS) / (hi - lo);
		return (q >= ONE_Q16) ? '1 : q[Q16_BITS-1:0];
	endfunction

	function automatic chan_t mix_chan(chan_t p, chan_t c, longint unsigned s);
		longint unsigned acc;
		acc = p * (ONE_Q16 - s) + c * s;
		return chan_t'(acc >> Q16_BITS);
	endfunction

	function automatic pixel_t predict_pixel(logic [CW-1:0] px, logic [CW-1:0] py,
			logic [CW-1:0] l, logic [CW-1:0] r, logic [CW-1:0] t, logic [CW-1:0] b,
			pixel_t src);
		longint unsigned dx, dy, d, ratio;
		pixel_t res;
		int ch;
		res = src;
		if (r > l && b > t && edge_dist != 0) begin
			dx    = near_edge_frac(px, l, r);
			dy    = near_edge_frac(py, t, b);
			d     = (dx < dy) ? dx : dy;
			ratio = (d << ED_FRAC) / edge_dist;
			// A ratio of one or more leaves no strength, so the pixel passes.
			if (ratio < ONE_Q16) begin
				for (ch = 0; ch < NCH; ch++)
					res[ch] = mix_chan(src[ch], edge_col[ch], ONE_Q16 - ratio);
			end
		end
		return res;
	endfunction

	task automatic log_error(string msg);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("[%0t] ERROR: %s", $realtime, msg);
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		pixel_t got, want;
		if (!arst_n) begin
			blended_q.delete();
			edge_dist <= EDGE_DISTANCE_RST;
			edge_col  <= EDGE_COL_RST;
			n_pending <= 0;
		end else begin
			if (done) begin
				got = {out_alpha, out_blue, out_green, out_red};
				if (blended_q.size() == 0) begin
					log_error($sformatf("pixel r=%02h g=%02h b=%02h a=%02h with no prediction",
						out_red, out_green, out_blue, out_alpha));
				end else begin
					want = blended_q.pop_front();
					if (got !== want)
						log_error($sformatf({"pixel %0d: expected r=%02h g=%02h b=%02h a=%02h, ",
							"got r=%02h g=%02h b=%02h a=%02h"}, result_cnt,
							want[CH_RED], want[CH_GREEN], want[CH_BLUE], want[CH_ALPHA],
							got[CH_RED], got[CH_GREEN], got[CH_BLUE], got[CH_ALPHA]));
				end
				result_cnt++;
			end
			if (start && !busy)
				blended_q.push_back(predict_pixel(pos_x, pos_y, tile_left, tile_right,
					tile_top, tile_bottom, {in_alpha, in_blue, in_green, in_red}));
			if (psel && penable && pwrite && pready) begin
				case (paddr[CFG_AW-1:2])
					REG_EDGE_DISTANCE: edge_dist <= pwdata[EDW-1:0];
					REG_EDGE_RED:      edge_col[CH_RED]   <= pwdata[7:0];
					REG_EDGE_GREEN:    edge_col[CH_GREEN] <= pwdata[7:0];
					REG_EDGE_BLUE:     edge_col[CH_BLUE]  <= pwdata[7:0];
					REG_EDGE_ALPHA:    edge_col[CH_ALPHA] <= pwdata[7:0];
					default: ;
				endcase
			end
			n_pending <= blended_q.size();
		end
		n_errors <= err_cnt;
	end

endmodule

### sim/tb_top.sv
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import tepb_pkg::*;

	localparam int CW              = $clog2(MAX_TEXTURE_SIZE_DEF + 1);
	localparam int TEX_MAX         = MAX_TEXTURE_SIZE_DEF;
	localparam logic [EDW-1:0] ED_ONE = EDW'(1 << ED_FRAC);
	localparam int NUM_PHASES      = 7;
	localparam int ITEMS_PER_PHASE = 233;
	localparam int LIMIT_CYCLES    = 400000;

	// Register slots past the last defined register; writes there must be dropped.
	localparam logic [CFG_AW-3:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [CFG_AW-3:0] REG_SPARE_LAST  = 3'd7;

	typedef enum int {AX_NORMAL, AX_EMPTY, AX_OUTSIDE} axis_mode_t;

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              start       = 1'b0;
	logic              busy;
	logic [CW-1:0]     pos_x       = '0;
	logic [CW-1:0]     pos_y       = '0;
	logic [CW-1:0]     tile_left   = '0;
	logic [CW-1:0]     tile_right  = '0;
	logic [CW-1:0]     tile_top    = '0;
	logic [CW-1:0]     tile_bottom = '0;
	logic [7:0]        in_red      = '0;
	logic [7:0]        in_green    = '0;
	logic [7:0]        in_blue     = '0;
	logic [7:0]        in_alpha    = '0;
	logic              done;
	logic [7:0]        out_red;
	logic [7:0]        out_green;
	logic [7:0]        out_blue;
	logic [7:0]        out_alpha;
	logic              psel        = 1'b0;
	logic              penable     = 1'b0;
	logic              pwrite      = 1'b0;
	logic [CFG_AW-1:0] paddr       = '0;
	logic [CFG_DW-1:0] pwdata      = '0;
	logic [CFG_DW-1:0] prdata;
	logic              pready;

	int n_pending;
	int n_errors;
	int cyc_cnt;
	bit idle_ok;

	always #2 clk = ~clk;

	tile_edge_proximity_blend u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y),
		.tile_left(tile_left), .tile_right(tile_right),
		.tile_top(tile_top), .tile_bottom(tile_bottom),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
		.done(done),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	tepb_checker #(.CW(CW)) u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.pos_x(pos_x), .pos_y(pos_y),
		.tile_left(tile_left), .tile_right(tile_right),
		.tile_top(tile_top), .tile_bottom(tile_bottom),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
		.done(done),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue), .out_alpha(out_alpha),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.n_pending(n_pending), .n_errors(n_errors)
	);

	// All tasks start and end right after a rising edge.
	task automatic send_pixel(input logic [CW-1:0] px, input logic [CW-1:0] py,
			input logic [CW-1:0] l, input logic [CW-1:0] r,
			input logic [CW-1:0] t, input logic [CW-1:0] b, input pixel_t src);
		start       <= 1'b1;
		pos_x       <= px;
		pos_y       <= py;
		tile_left   <= l;
		tile_right  <= r;
		tile_top    <= t;
		tile_bottom <= b;
		in_red      <= src[CH_RED];
		in_green    <= src[CH_GREEN];
		in_blue     <= src[CH_BLUE];
		in_alpha    <= src[CH_ALPHA];
		do @(posedge clk); while (busy);
	endtask

	task automatic idle_burst(input int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// The first edge lets the checker count a transfer taken at the current edge.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (n_pending != 0) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_AW-3:0] idx, input logic [CFG_DW-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Upper data bits carry junk that the registers must drop.
	task automatic set_config(input logic [EDW-1:0] ed, input pixel_t col);
		logic [CFG_DW-1:0] val;
		val = $urandom;
		val[EDW-1:0] = ed;
		cfg_write(REG_EDGE_DISTANCE, val);
		val = $urandom;
		val[7:0] = col[CH_RED];
		cfg_write(REG_EDGE_RED, val);
		val = $urandom;
		val[7:0] = col[CH_GREEN];
		cfg_write(REG_EDGE_GREEN, val);
		val = $urandom;
		val[7:0] = col[CH_BLUE];
		cfg_write(REG_EDGE_BLUE, val);
		val = $urandom;
		val[7:0] = col[CH_ALPHA];
		cfg_write(REG_EDGE_ALPHA, val);
		cfg_write((CFG_AW-2)'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)), $urandom);
	endtask

	// Most spans are small so that pixels land near a bound often.
	task automatic gen_axis(input axis_mode_t mode, output logic [CW-1:0] lo,
			output logic [CW-1:0] hi, output logic [CW-1:0] pos);
		int sz, a, b, p;
		case ($urandom_range(9, 0))
			0, 1, 2, 3, 4, 5: sz = $urandom_range(32, 1);
			6, 7, 8:          sz = $urandom_range(1024, 33);
			default:          sz = $urandom_range(TEX_MAX, 1025);
		endcase
		a = $urandom_range(TEX_MAX - sz, 0);
		b = a + sz;
		p = $urandom_range(b - 1, a);
		if ($urandom_range(15, 0) == 0)
			p = b;
		case (mode)
			AX_EMPTY:   b = $urandom_range(a, 0);
			AX_OUTSIDE: p = $urandom_range(TEX_MAX, 0);
			default: ;
		endcase
		lo  = CW'(a);
		hi  = CW'(b);
		pos = CW'(p);
	endtask

	task automatic send_random();
		logic [CW-1:0] px, py, l, r, t, b;
		axis_mode_t xm, ym;
		int pick;
		pick = $urandom_range(19, 0);
		xm = AX_NORMAL;
		ym = AX_NORMAL;
		if (pick == 15)
			xm = AX_EMPTY;
		else if (pick == 16)
			ym = AX_EMPTY;
		else if (pick >= 17) begin
			xm = $urandom_range(1, 0) ? AX_OUTSIDE : AX_NORMAL;
			ym = (xm == AX_NORMAL || $urandom_range(1, 0)) ? AX_OUTSIDE : AX_NORMAL;
		end
		gen_axis(xm, l, r, px);
		gen_axis(ym, t, b, py);
		send_pixel(px, py, l, r, t, b, pixel_t'($urandom));
	endtask

	initial begin : watchdog
		for (cyc_cnt = 0; cyc_cnt < LIMIT_CYCLES; cyc_cnt++)
			@(posedge clk);
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int ph, k;
		logic [EDW-1:0] ed;
		pixel_t col;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Effect disabled by the reset value of the reach.
		send_pixel(13'd0, 13'd0, 13'd0, 13'd4096, 13'd0, 13'd4096, 32'hFFFFFFFF);
		send_pixel(13'd4096, 13'd4096, 13'd0, 13'd4096, 13'd0, 13'd4096, 32'h00000000);

		drain();
		set_config(ED_ONE, 32'hA55AFF00);
		send_pixel(13'd0, 13'd0, 13'd0, 13'd16, 13'd0, 13'd16, 32'h44332211);
		send_pixel(13'd8, 13'd8, 13'd0, 13'd16, 13'd0, 13'd16, 32'h44332211);
		send_pixel(13'd15, 13'd3, 13'd0, 13'd16, 13'd0, 13'd16, 32'hFFFFFFFF);
		// Empty and inverted tiles pass the pixel through.
		send_pixel(13'd100, 13'd5, 13'd100, 13'd100, 13'd0, 13'd16, 32'h12345678);
		send_pixel(13'd5, 13'd4096, 13'd0, 13'd16, 13'd4096, 13'd4096, 32'h87654321);
		send_pixel(13'd50, 13'd5, 13'd4096, 13'd0, 13'd0, 13'd16, 32'hDEADBEEF);
		send_pixel(13'd5, 13'd5, 13'd0, 13'd16, 13'd10, 13'd3, 32'hCAFEF00D);
		// Far outside a one-pixel tile the distance saturates.
		send_pixel(13'd4096, 13'd4096, 13'd0, 13'd1, 13'd0, 13'd1, 32'h00000000);
		send_pixel(13'd2048, 13'd2048, 13'd0, 13'd4096, 13'd0, 13'd4096, 32'h80808080);
		send_pixel(13'd4096, 13'd0, 13'd0, 13'd4096, 13'd0, 13'd4096, 32'hFF00FF00);

		drain();
		set_config(ED_ONE >> 1, 32'h0180_00FF);
		// Half the reach at half a tile leaves exactly zero strength.
		send_pixel(13'd4, 13'd4, 13'd0, 13'd8, 13'd0, 13'd8, 32'h55AA55AA);
		send_pixel(13'd3, 13'd4, 13'd0, 13'd8, 13'd0, 13'd8, 32'h55AA55AA);
		send_pixel(13'd4, 13'd0, 13'd0, 13'd8, 13'd0, 13'd8, 32'hFFFFFFFF);
		send_pixel(13'd4096, 13'd4096, 13'd0, 13'd1, 13'd0, 13'd1, 32'h01020304);
		send_pixel(13'd4096, 13'd4096, 13'd4095, 13'd4096, 13'd4095, 13'd4096, 32'h00000000);

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			drain();
			col = pixel_t'($urandom);
			case (ph)
				0: begin
					ed  = '1;
					col = '0;
				end
				1: begin
					ed  = 16'd1;
					col = '1;
				end
				2: ed = ED_ONE;
				3: ed = EDW'($urandom_range(8192, 1));
				4: ed = EDW'($urandom);
				5: ed = '0;
				default: ed = EDW'($urandom_range(4096, 256));
			endcase
			set_config(ed, col);
			// The closing phase streams back to back.
			idle_ok = (ph != NUM_PHASES - 1);
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (ph == 3 && k == ITEMS_PER_PHASE / 2)
					drain();
				if (idle_ok && $urandom_range(5, 0) == 0)
					idle_burst($urandom_range(11, 1));
				send_random();
			end
		end

		drain();
		repeat (PIPE_LATENCY + 8) @(posedge clk);
		if (n_errors == 0 && n_pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
